// ===== hw/rtl/kvi_pkg.sv =====
// ============================================================================
// kvi_pkg
// Types and constants shared by the keyframe vector interpolator modules.
// ============================================================================
package kvi_pkg;

  localparam int unsigned MaxKeys    = 64;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CountW     = 7;
  localparam int unsigned FifoDepth  = 2;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_CLAMP  = 2'd1,
    ST_ZERO   = 2'd2
  } status_e;

  // Interpolation engine sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_SRCH, S_SEG, S_SEGW, S_CHK, S_DIV, S_MUL, S_ACC, S_EMIT
  } eng_state_e;

  typedef struct packed {
    logic        action;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]  segment;
    logic [1:0]  status;
  } out_item_t;

  // Command from the front end to the interpolation engine.
  typedef struct packed {
    logic        action;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic [95:0] key_vec;
    logic [31:0] query_time;
    logic [CountW-1:0] count;
  } cmd_t;

endpackage

// ===== hw/rtl/kvi_front.sv =====
// ============================================================================
// kvi_front
// Accepts beats, clamps the key count and queues commands for the engine.
// ============================================================================
module kvi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  kvi_pkg::in_item_t in_item_i,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output kvi_pkg::cmd_t     cmd_o
);
  import kvi_pkg::*;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] eff_count;
  cmd_t              fifo_q [FifoDepth];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        fill_q;
  logic              wr_en, rd_en;

  // Key count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Zero acts as one, above the table size acts as the table size
  always_comb begin
    eff_count = count_q;
    if (count_q == '0) eff_count = CountW'(1);
    if (count_q > CountW'(MaxKeys)) eff_count = CountW'(MaxKeys);
  end

  assign full        = (fill_q == 2'(FifoDepth));
  assign wr_en       = push && !full;
  assign cmd_valid_o = (fill_q != '0);
  assign rd_en       = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Command queue payload
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= '{action: in_item_i.action, key_index: in_item_i.key_index,
                            key_time: in_item_i.key_time,
                            key_vec: {in_item_i.key_x, in_item_i.key_y, in_item_i.key_z},
                            query_time: in_item_i.query_time, count: eff_count};
    end
  end

  // Command queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ===== hw/rtl/kvi_engine.sv =====
// ============================================================================
// kvi_engine
// Holds the key tables, searches the segment, divides serially and blends.
// ============================================================================
module kvi_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  kvi_pkg::cmd_t      cmd_i,
  output logic               empty,
  input  logic               pop,
  output kvi_pkg::out_item_t out_item_o
);
  import kvi_pkg::*;

  localparam int unsigned DivW = 32 + FracBits;

  logic [31:0] time_mem [MaxKeys];
  logic [95:0] vec_mem  [MaxKeys];

  eng_state_e        state_q, state_d;
  cmd_t              cmd_q;
  logic [IdxW:0]     idx_q, idx_d;
  logic [IdxW-1:0]   t_addr, v_addr;
  logic [31:0]       t_rd_q;
  logic [95:0]       v_rd_q;
  logic [31:0]       t0_q, t0_d;
  logic [95:0]       v0_q, v0_d;
  logic [5:0]        seg_q, seg_d;
  logic [1:0]        st_q, st_d;
  logic [DivW-1:0]   num_q, num_d;
  logic [32:0]       rem_q, rem_d;
  logic [FracBits:0] fac_q, fac_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [1:0]        comp_q, comp_d;
  logic signed [32:0] diff;
  logic signed [FracBits+33:0] prod_q, prod_d;
  logic signed [33:0] sum;
  logic signed [31:0] sat;
  logic [95:0]       res_q, res_d;
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;
  logic [32:0]       rem_sh;
  logic [31:0]       dt;

  // Table write port and registered read ports
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_i.action == ACT_LOAD) begin
      time_mem[cmd_i.key_index] <= cmd_i.key_time;
      vec_mem[cmd_i.key_index]  <= cmd_i.key_vec;
    end
    t_rd_q <= time_mem[t_addr];
    v_rd_q <= vec_mem[v_addr];
  end

  assign t_addr = idx_d[IdxW-1:0];
  assign v_addr = idx_d[IdxW-1:0];
  assign cmd_ready_o = (state_q == S_IDLE) && (cmd_i.action == ACT_LOAD || !out_v_q);
  assign empty       = !out_v_q;
  assign out_item_o  = out_q;
  assign dt          = t_rd_q - t0_q;

  // Blend helpers for the current component
  always_comb begin
    diff = 33'(signed'(v_rd_q[95-32*comp_q -: 32])) - 33'(signed'(v0_q[95-32*comp_q -: 32]));
    sum  = 34'(signed'(v0_q[95-32*comp_q -: 32]))
         + 34'(prod_q >>> FracBits);
    if (sum > 34'sh7FFFFFFF)       sat = 32'sh7FFFFFFF;
    else if (sum < -34'sh80000000) sat = -32'sh80000000;
    else                           sat = sum[31:0];
    rem_sh = {rem_q[31:0], num_q[DivW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    idx_q <= idx_d; t0_q <= t0_d; v0_q <= v0_d; seg_q <= seg_d; st_q <= st_d;
    num_q <= num_d; rem_q <= rem_d; fac_q <= fac_d; cnt_q <= cnt_d;
    comp_q <= comp_d; prod_q <= prod_d; res_q <= res_d; out_q <= out_d;
  end

  // Sequencer: search, divide, three multiplies; single-key, clamped and zero-length queries emit a key directly
  always_comb begin
    state_d = state_q; idx_d = idx_q; t0_d = t0_q; v0_d = v0_q; seg_d = seg_q;
    st_d = st_q; num_d = num_q; rem_d = rem_q; fac_d = fac_q; cnt_d = cnt_q;
    comp_d = comp_q; prod_d = prod_q; res_d = res_q; out_v_d = out_v_q; out_d = out_q;
    if (out_v_q && pop) out_v_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (cmd_valid_i && cmd_ready_o && cmd_i.action == ACT_QUERY) begin
          if (cmd_i.count == CountW'(1)) begin
            idx_d = '0; seg_d = '0; st_d = ST_INTERP; state_d = S_RD0;
          end else begin
            idx_d = (IdxW+1)'(1); state_d = S_SRCH;
          end
        end
      end
      // single key: read slot 0 and emit; a search that runs past the last key also emits that key here
      S_RD0: begin
        res_d = v_rd_q; state_d = S_EMIT;
      end
      // t_rd_q holds time[idx_q]; first key time above t ends the search
      S_SRCH: begin
        if (cmd_q.query_time < t_rd_q) begin
          seg_d = 6'(idx_q - 1'b1); idx_d = idx_q - 1'b1; state_d = S_SEG;
        end else if (idx_q + 1'b1 >= (IdxW+1)'(cmd_q.count)) begin
          seg_d = 6'(idx_q); st_d = ST_CLAMP; state_d = S_RD0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      // start key available; request the end key
      S_SEG: begin
        t0_d = t_rd_q; v0_d = v_rd_q; idx_d = idx_q + 1'b1; state_d = S_SEGW;
      end
      S_SEGW: begin
        state_d = S_CHK;
      end
      // end key available: classify
      S_CHK: begin
        if (t_rd_q <= t0_q) begin
          st_d = ST_ZERO; res_d = v0_q; state_d = S_EMIT;
        end else if (cmd_q.query_time < t0_q) begin
          st_d = ST_CLAMP; res_d = v0_q; state_d = S_EMIT;
        end else begin
          st_d = ST_INTERP;
          num_d = {cmd_q.query_time - t0_q, FracBits'(0)};
          rem_d = '0; fac_d = '0; cnt_d = 6'(DivW); state_d = S_DIV;
        end
      end
      // restoring division, one bit a cycle
      S_DIV: begin
        num_d = num_q << 1;
        if (rem_sh >= {1'b0, dt}) begin
          rem_d = rem_sh - {1'b0, dt}; fac_d = {fac_q[FracBits-1:0], 1'b1};
        end else begin
          rem_d = rem_sh; fac_d = {fac_q[FracBits-1:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          comp_d = '0; state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = (FracBits+34)'(diff) * (FracBits+34)'(signed'({1'b0, fac_q}));
        state_d = S_ACC;
      end
      S_ACC: begin
        res_d[95-32*comp_q -: 32] = sat;
        if (comp_q == 2'd2) state_d = S_EMIT;
        else begin
          comp_d = comp_q + 1'b1; state_d = S_MUL;
        end
      end
      S_EMIT: begin
        if (!out_v_q || pop) begin
          out_v_d = 1'b1;
          out_d = '{out_x: res_q[95:64], out_y: res_q[63:32], out_z: res_q[31:0],
                    segment: seg_q, status: st_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/keyframe_vector_interpolator_top.sv =====
// ============================================================================
// keyframe_vector_interpolator_top
// Linear interpolation of three-component vectors over a keyframe table.
// ============================================================================
// Usage: push beats on the input queue (push/full). A load beat (action 0)
// writes one keyframe slot and gives no result; a query beat (action 1)
// gives one result on the output queue (empty/pop) holding the vector,
// the segment start index and a status code.
// key_count is written through cfg_we_i/cfg_wdata_i while the block is idle.
// A front end queues two commands so the input can keep taking beats while
// the engine works. A query searches the keys with one memory read per key,
// divides in the serial divider and makes three multiply-accumulate passes.
// The engine holds its finished result until it is popped; then the
// command queue fills and full rises. Reset clears control state and sets
// key_count to 1; the key tables are undefined until loaded.
// ============================================================================
module keyframe_vector_interpolator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  kvi_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output kvi_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i
);
  import kvi_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  kvi_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  kvi_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .empty, .pop, .out_item_o
  );

endmodule

// ===== dv/keyframe_vector_interpolator_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// keyframe_vector_interpolator_top_test
// Self-checking test of the keyframe vector interpolator. Keyframes are
// loaded and queried through the input queue, and each result is checked
// against a predictor kept in the test. Key counts, segment edges, clamping,
// zero-length intervals and saturation are covered first. Random load and
// query traffic follows, with random idle cycles on both sides.
// ============================================================================
module keyframe_vector_interpolator_top_test;
  import kvi_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;
  logic      cfg_we_i;
  logic [6:0] cfg_wdata_i;

  keyframe_vector_interpolator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Predictor state: key tables and key count
  logic [31:0]        key_times [MaxKeys];
  logic signed [31:0] key_vecs  [MaxKeys][3];
  logic [6:0]         key_count_q;

  out_item_t expected_vectors[$];
  int        mismatch_count;
  int        cycle_count;
  bit        quiet_send;
  bit        quiet_pop;

  localparam int CycleLimit = 2_000_000;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Saturate a wide value to the signed output range
  function automatic logic signed [31:0] clip_value(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_item_t interpolate_query(logic [31:0] t);
    out_item_t   r;
    int          n, seg;
    bit          found;
    longint      t0, t1, fct, s, d, p;
    n = (key_count_q == 0) ? 1 : ((key_count_q > MaxKeys) ? MaxKeys : key_count_q);
    r = '0;
    if (n == 1) begin
      r.out_x = key_vecs[0][0]; r.out_y = key_vecs[0][1]; r.out_z = key_vecs[0][2];
      r.status = ST_INTERP;
      return r;
    end
    found = 0;
    seg = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && t < key_times[i+1]) begin
        seg = i;
        found = 1;
      end
    end
    if (!found) begin
      seg = n - 1;
      r.status = ST_CLAMP;
    end else begin
      t0 = key_times[seg];
      t1 = key_times[seg+1];
      if (t1 <= t0) r.status = ST_ZERO;
      else if (t < t0) r.status = ST_CLAMP;
      else r.status = ST_INTERP;
    end
    r.segment = seg[5:0];
    if (r.status != ST_INTERP) begin
      r.out_x = key_vecs[seg][0]; r.out_y = key_vecs[seg][1]; r.out_z = key_vecs[seg][2];
      return r;
    end
    fct = ((longint'(t) - t0) <<< FracBits) / (t1 - t0);
    for (int c = 0; c < 3; c++) begin
      s = key_vecs[seg][c];
      d = longint'(key_vecs[seg+1][c]) - s;
      p = d * fct;
      // floor toward minus infinity
      p = p >>> FracBits;
      if (c == 0) r.out_x = clip_value(s + p);
      else if (c == 1) r.out_y = clip_value(s + p);
      else r.out_z = clip_value(s + p);
    end
    return r;
  endfunction

  // Send one beat; update predictor when accepted. push stays high after
  // the accept so the next beat can follow directly.
  task automatic send_item(in_item_t it);
    while (!quiet_send && $urandom_range(99) < 18) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    if (it.action == ACT_LOAD) begin
      key_times[it.key_index]   = it.key_time;
      key_vecs[it.key_index][0] = it.key_x;
      key_vecs[it.key_index][1] = it.key_y;
      key_vecs[it.key_index][2] = it.key_z;
    end else begin
      expected_vectors.push_back(interpolate_query(it.query_time));
    end
  endtask

  task automatic load_key(int idx, logic [31:0] kt, logic [31:0] x, y, z);
    in_item_t it;
    it = '{action: ACT_LOAD, key_index: idx[5:0], key_time: kt, key_x: x, key_y: y,
           key_z: z, query_time: $urandom()};
    send_item(it);
  endtask

  task automatic query_at(logic [31:0] t);
    in_item_t it;
    it = '{action: ACT_QUERY, key_index: 6'($urandom()), key_time: $urandom(),
           key_x: $urandom(), key_y: $urandom(), key_z: $urandom(), query_time: t};
    send_item(it);
  endtask

  // Wait for all results, then let a load settle before a register write
  task automatic write_key_count(logic [6:0] n);
    push <= 1'b0;
    while (expected_vectors.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_count_q = n;
  endtask

  // Result checker and pop driver
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_vectors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %p", out_item_o);
      end else begin
        e = expected_vectors.pop_front();
        if (out_item_o.out_x !== e.out_x || out_item_o.out_y !== e.out_y ||
            out_item_o.out_z !== e.out_z || out_item_o.segment !== e.segment ||
            out_item_o.status !== e.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p got %p", e, out_item_o);
        end
      end
    end
    if (rst_ni) pop <= quiet_pop || ($urandom_range(99) >= 18);
  end

  task automatic test_single_key();
    load_key(0, 32'h0001_0000, 32'h7fffffff, 32'h80000000, 32'h0);
    query_at(32'h0);
    query_at(32'hffffffff);
    load_key(1, 32'h0002_0000, 32'h80000000, 32'h7fffffff, 32'h0001_8000);
    write_key_count(7'd0);
    query_at(32'h0001_8000);
  endtask

  task automatic test_edges();
    load_key(2, 32'h0002_0000, 32'h1234, 32'h5678, 32'h9abc);
    load_key(3, 32'hffffffff, 32'h0, 32'hffff0000, 32'h7fffffff);
    write_key_count(7'd4);
    query_at(32'h0);
    query_at(32'h0001_0000);
    query_at(32'h0001_ffff);
    query_at(32'h0002_0000);
    query_at(32'hfffffffe);
    query_at(32'hffffffff);
    write_key_count(7'd2);
    query_at(32'h0001_4000);
    query_at(32'h0003_0000);
  endtask

  // Random tables; most keys ascending, some equal or reversed
  task automatic test_random(int items);
    int n, sent;
    logic [31:0] tm;
    logic [6:0] cfgs[6];
    cfgs = '{7'd3, 7'd64, 7'd127, 7'd8, 7'd17, 7'd1};
    sent = 0;
    for (int ph = 0; sent < items; ph++) begin
      n = cfgs[ph % 6];
      if (n > 64) n = 64;
      if (ph % 6 == 1) quiet_send = 1; else quiet_send = 0;
      quiet_pop = (ph % 6 == 1);
      tm = $urandom_range(3) == 0 ? 0 : $urandom_range(32'h10000);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0) tm = $urandom_range(1) ? tm : tm - $urandom_range(5);
        else tm = tm + ($urandom_range(3) == 0 ? $urandom() >> $urandom_range(31)
                                                : $urandom_range(32'h40000));
        load_key(k, tm, $urandom(), $urandom(), $urandom());
        sent++;
      end
      write_key_count(cfgs[ph % 6]);
      repeat (n < 8 ? 20 : 40) begin
        if ($urandom_range(9) == 0) tm = $urandom();
        else tm = key_times[$urandom_range(n - 1)] + $urandom_range(32'h30000) - 32'h8000;
        query_at(tm);
        sent++;
      end
    end
    quiet_send = 0;
    quiet_pop = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cycle_count = 0;
    mismatch_count = 0;
    quiet_send = 0;
    quiet_pop = 0;
    key_count_q = 7'd1;
    foreach (key_times[i]) begin
      key_times[i] = '0;
      key_vecs[i] = '{0, 0, 0};
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_key();
    test_edges();
    test_random(1500);
    push <= 1'b0;
    while (expected_vectors.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && expected_vectors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/kvi_pkg.sv
hw/rtl/kvi_front.sv
hw/rtl/kvi_engine.sv
hw/rtl/keyframe_vector_interpolator_top.sv
dv/keyframe_vector_interpolator_top_test.sv
